>>> design/idluhn_pkg.sv
// Shared types, constants and helper functions for the ID number check core.
// No dependencies; imported by every module of the block.
`default_nettype none

package idluhn_pkg;

  localparam int CHAR_W  = 8;
  localparam int POS_W   = 4;
  localparam int SUM_W   = 4;
  localparam int FIELD_W = 7;
  localparam int DIGIT_W = 4;
  localparam int LEN_W   = 5;
  localparam int DATA_W  = 8;

  localparam logic [POS_W-1:0] MAX_CHARS   = POS_W'(10);
  localparam logic [POS_W-1:0] MONTH_START = POS_W'(2);
  localparam logic [POS_W-1:0] DAY_START   = POS_W'(4);
  localparam logic [POS_W-1:0] DATE_END    = POS_W'(6);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  localparam logic [LEN_W-1:0] LEN_LONG  = LEN_W'(31);
  localparam logic [LEN_W-1:0] LEN_SHORT = LEN_W'(30);
  localparam logic [LEN_W-1:0] LEN_LEAP  = LEN_W'(29);
  localparam logic [LEN_W-1:0] LEN_FEB   = LEN_W'(28);
  localparam logic [LEN_W-1:0] LEN_NONE  = LEN_W'(0);

  localparam logic [SUM_W:0] MOD_BASE = (SUM_W + 1)'(10);

  typedef struct packed {
    logic date_ok;
    logic checksum_ok;
    logic number_ok;
  } verdict_t;

  // digit sum of twice a decimal digit
  function automatic logic [SUM_W-1:0] doubled_digit_sum(input logic [DIGIT_W-1:0] d);
    logic [SUM_W-1:0] r;
    case (d)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd6;
      4'd4:    r = 4'd8;
      4'd5:    r = 4'd1;
      4'd6:    r = 4'd3;
      4'd7:    r = 4'd5;
      4'd8:    r = 4'd7;
      4'd9:    r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // both operands below ten
  function automatic logic [SUM_W-1:0] add_mod10(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MOD_BASE) begin
      s = s - MOD_BASE;
    end
    return s[SUM_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] month_length(input logic [FIELD_W-1:0] year,
                                                    input logic [FIELD_W-1:0] month);
    logic [LEN_W-1:0] r;
    case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = LEN_LONG;
      7'd4, 7'd6, 7'd9, 7'd11:                    r = LEN_SHORT;
      7'd2:    r = (year[1:0] == 2'b00) ? LEN_LEAP : LEN_FEB;
      default: r = LEN_NONE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/id_number_luhn_date_check_core.sv
// Top level of the ID number check core: input register, accumulator, result register.
// Depends on idluhn_pkg and idluhn_accum.
`default_nettype none

// Takes one ASCII character per beat, leftmost first, with tlast on the final
// character, and gives one result beat per number: number_ok, checksum_ok and
// date_ok. One character is taken every clock cycle unless a held result
// stalls the input side; the only per-character path is the accumulator
// update between the input register and the state registers. The last
// character is held in the input register until it advances, and the
// verdict is loaded into the result register as it does; the first
// character of the next number may be taken in the same cycle. A held
// result stalls the input side only once a second last character is
// waiting behind it. Characters beyond the tenth do not change the verdict.

module id_number_luhn_date_check_core import idluhn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] char_code
  input  logic              s_axis_tlast,   // last_char
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata    // [0] number_ok, [1] checksum_ok, [2] date_ok
);

  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;
  logic              out_free;
  logic              advance;
  verdict_t          verdict;
  verdict_t          result;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || advance;

  idluhn_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .char_code (in_char),
    .last_char (in_last),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance && in_last) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (advance && in_last) begin
      result <= verdict;
    end
  end

  assign m_axis_tdata = {{(DATA_W-3){1'b0}}, result.date_ok, result.checksum_ok,
                         result.number_ok};

  a_held_char: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_char) && $stable(in_last))
    else $error("stalled character changed in the input register");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready) |-> $past(advance && in_last))
    else $error("result beat loaded without a last character");

  a_verdict_and: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[0] == (m_axis_tdata[1] & m_axis_tdata[2]))
    else $error("number_ok disagrees with checksum_ok and date_ok");

endmodule

`default_nettype wire

>>> design/idluhn_accum.sv
// Running Luhn sums and YYMMDD capture for one ID number, plus the final verdict.
// Depends on idluhn_pkg.
`default_nettype none

module idluhn_accum import idluhn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last_char,
  output verdict_t          verdict
);

  logic [POS_W-1:0]   char_position, char_position_next;
  logic [SUM_W-1:0]   sum_even_length, sum_even_length_next;
  logic [SUM_W-1:0]   sum_odd_length, sum_odd_length_next;
  logic [FIELD_W-1:0] year_value, year_value_next;
  logic [FIELD_W-1:0] month_value, month_value_next;
  logic [FIELD_W-1:0] day_value, day_value_next;
  logic               field_ended, field_ended_next;

  logic               is_digit;
  logic [CHAR_W-1:0]  char_offset;
  logic [DIGIT_W-1:0] digit;
  logic [SUM_W-1:0]   doubled;
  logic               ended_now;
  logic [FIELD_W-1:0] field_cur;
  logic [FIELD_W+3:0] field_scaled;
  logic [FIELD_W-1:0] field_new;
  logic [SUM_W-1:0]   sum_sel;
  logic [LEN_W-1:0]   len;

  always_comb begin
    is_digit    = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    char_offset = char_code - CHAR_ZERO;
    digit       = is_digit ? char_offset[DIGIT_W-1:0] : '0;
    doubled     = doubled_digit_sum(digit);

    ended_now = char_position[0] & field_ended;
    if (char_position < MONTH_START) begin
      field_cur = year_value;
    end else if (char_position < DAY_START) begin
      field_cur = month_value;
    end else begin
      field_cur = day_value;
    end
    field_scaled = {field_cur, 3'b000} + {2'b00, field_cur, 1'b0}
                 + {{(FIELD_W+3-DIGIT_W){1'b0}}, digit};
    field_new    = field_scaled[FIELD_W-1:0];

    char_position_next   = char_position;
    sum_even_length_next = sum_even_length;
    sum_odd_length_next  = sum_odd_length;
    year_value_next      = year_value;
    month_value_next     = month_value;
    day_value_next       = day_value;
    field_ended_next     = field_ended;

    if (char_position < MAX_CHARS) begin
      if (!char_position[0]) begin
        sum_even_length_next = add_mod10(sum_even_length, doubled);
        sum_odd_length_next  = add_mod10(sum_odd_length, digit);
      end else begin
        sum_even_length_next = add_mod10(sum_even_length, digit);
        sum_odd_length_next  = add_mod10(sum_odd_length, doubled);
      end
      if (char_position < DATE_END) begin
        if (!ended_now && is_digit) begin
          if (char_position < MONTH_START) begin
            year_value_next = field_new;
          end else if (char_position < DAY_START) begin
            month_value_next = field_new;
          end else begin
            day_value_next = field_new;
          end
        end
        field_ended_next = ended_now | ~is_digit;
      end
      char_position_next = char_position + POS_W'(1);
    end

    sum_sel = char_position_next[0] ? sum_odd_length_next : sum_even_length_next;
    len     = month_length(year_value_next, month_value_next);
    verdict.checksum_ok = (sum_sel == '0);
    verdict.date_ok     = (day_value_next != '0)
                        && (day_value_next <= {{(FIELD_W-LEN_W){1'b0}}, len});
    verdict.number_ok   = verdict.checksum_ok & verdict.date_ok;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_char)) begin
      char_position   <= '0;
      sum_even_length <= '0;
      sum_odd_length  <= '0;
      year_value      <= '0;
      month_value     <= '0;
      day_value       <= '0;
      field_ended     <= 1'b0;
    end else if (step) begin
      char_position   <= char_position_next;
      sum_even_length <= sum_even_length_next;
      sum_odd_length  <= sum_odd_length_next;
      year_value      <= year_value_next;
      month_value     <= month_value_next;
      day_value       <= day_value_next;
      field_ended     <= field_ended_next;
    end
  end

endmodule

`default_nettype wire
